// File: rtl/core/ptt_pkg.sv
// Shared types and codes for the periodic timer table.
package ptt_pkg;

    localparam int TIME_W   = 48;
    localparam int IVAL_W   = 32;
    localparam int ID_W     = 4;
    localparam int COUNT_W  = 5;
    localparam int MAX_IDS  = 16;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_IVAL  = 2'd1,
        STAT_USED      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_FIRE   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   timer_id;
        logic [IVAL_W-1:0] interval;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [ID_W-1:0]    fired_id;
        logic [COUNT_W-1:0] active_count;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [IVAL_W-1:0] interval;
        logic [TIME_W-1:0] deadline;
    } slot_entry_t;

endpackage

// File: rtl/core/periodic_timer_table.sv
// Periodic timer table: slot memory, command sequencer and response register.
//
//  channel | signals                  | moves
//  --------+--------------------------+-----------------------------------
//  request | req_valid req_ready req  | add, remove or update command
//  result  | rsp_valid rsp_ready rsp  | status, fire and done results
//
// Add, remove and unused commands give a single result each. Update walks the
// slots in order, gives a fire result for each due slot and then a done result;
// a due slot waits on the 48-step remainder divider for its new deadline.
// Reset clears all slots at once; slot memory needs no clearing pass.
// A stalled result holds the sequencer only where it has a next result to give.
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int SLOTS = (NUM_TIMERS < MAX_IDS) ? NUM_TIMERS : MAX_IDS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_RD,
        S_CHK,
        S_DIV,
        S_FIRE,
        S_DONE
    } state_t;

    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [COUNT_W-1:0] active_reg, active_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    slot_entry_t        mem [SLOTS];
    slot_entry_t        rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    slot_entry_t        mem_wdata;

    logic               div_start, div_busy, div_done;
    logic [IVAL_W-1:0]  div_rem;

    logic               emit_ok;
    logic               id_in_range;
    logic [IDX_W-1:0]   req_idx;
    logic [TIME_W:0]    add_sum;
    logic [TIME_W-1:0]  add_deadline;
    logic [TIME_W-1:0]  fire_base;
    logic [TIME_W:0]    fire_sum;
    logic [TIME_W-1:0]  fire_deadline;
    logic               last_slot;

    ptt_rem_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req_reg.now - rdata_reg.deadline),
        .divisor   (rdata_reg.interval),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        emit_ok     = !rsp_valid_reg || rsp_ready;
        id_in_range = ({1'b0, req_reg.timer_id} < (ID_W + 1)'(SLOTS));
        req_idx     = IDX_W'(req_reg.timer_id);
        add_sum     = {1'b0, req_reg.now} + (TIME_W + 1)'(req_reg.interval);
        add_deadline  = add_sum[TIME_W] ? TIME_TOP : add_sum[TIME_W-1:0];
        fire_base     = req_reg.now - TIME_W'(div_rem);
        fire_sum      = {1'b0, fire_base} + (TIME_W + 1)'(rdata_reg.interval);
        fire_deadline = fire_sum[TIME_W] ? TIME_TOP : fire_sum[TIME_W-1:0];
        last_slot     = (idx_reg == IDX_W'(SLOTS - 1));

        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '{interval: rdata_reg.interval, deadline: fire_deadline};
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    idx_next = '0;
                    state_next = (req.action == ACT_UPDATE) ? S_RD : S_CMD;
                end
            end
            S_CMD:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.kind         = KIND_STATUS;
                    rsp_next.status       = STAT_OK;
                    rsp_next.fired_id     = req_reg.timer_id;
                    rsp_next.last         = 1'b1;
                    rsp_next.active_count = active_reg;
                    state_next            = S_IDLE;
                    if (req_reg.action == ACT_ADD)
                    begin
                        priority if (req_reg.interval == '0)
                            rsp_next.status = STAT_BAD_IVAL;
                        else if (!id_in_range)
                            rsp_next.status = STAT_NOT_FOUND;
                        else if (valid_reg[req_idx])
                            rsp_next.status = STAT_USED;
                        else
                        begin
                            valid_next[req_idx]   = 1'b1;
                            active_next           = active_reg + 1'b1;
                            rsp_next.active_count = active_reg + 1'b1;
                            mem_we                = 1'b1;
                            mem_waddr             = req_idx;
                            mem_wdata = '{interval: req_reg.interval, deadline: add_deadline};
                        end
                    end
                    else if (req_reg.action == ACT_REMOVE)
                    begin
                        if (!id_in_range || !valid_reg[req_idx])
                            rsp_next.status = STAT_NOT_FOUND;
                        else
                        begin
                            valid_next[req_idx]   = 1'b0;
                            active_next           = active_reg - 1'b1;
                            rsp_next.active_count = active_reg - 1'b1;
                        end
                    end
                end
            end
            S_RD:
            begin
                if (valid_reg[idx_reg])
                    state_next = S_CHK;
                else if (last_slot)
                    state_next = S_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_CHK:
            begin
                if (req_reg.now < rdata_reg.deadline)
                begin
                    if (last_slot)
                        state_next = S_DONE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FIRE;
                end
            end
            S_FIRE:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.kind         = KIND_FIRE;
                    rsp_next.status       = STAT_OK;
                    rsp_next.fired_id     = ID_W'(idx_reg);
                    rsp_next.active_count = active_reg;
                    rsp_next.last         = 1'b0;
                    if (last_slot)
                        state_next = S_DONE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.kind         = KIND_STATUS;
                    rsp_next.status       = STAT_OK;
                    rsp_next.fired_id     = '0;
                    rsp_next.active_count = active_reg;
                    rsp_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            active_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[idx_reg];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == COUNT_W'($countones(valid_reg)))
        else $error("active count differs from occupied slots");

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.kind == KIND_FIRE |-> !rsp_reg.last
            && rsp_reg.status == STAT_OK)
        else $error("fire result marked last or with status");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy && state_reg == S_CHK)
        else $error("divider started while busy");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider result outside its wait state");

endmodule

// File: rtl/core/ptt_rem_div.sv
// Bit-serial restoring divider that yields the remainder of elapsed time by interval.
module ptt_rem_div
    import ptt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [IVAL_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [IVAL_W-1:0] remainder
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] dvd_reg;
    logic [IVAL_W-1:0] dvs_reg;
    logic [IVAL_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [IVAL_W:0]   trial;
    logic [IVAL_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[TIME_W-1]};
        if (trial >= {1'b0, dvs_reg})
            rem_next = IVAL_W'(trial - {1'b0, dvs_reg});
        else
            rem_next = trial[IVAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TIME_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: tb/sv/tb_periodic_timer_table.sv
// Testbench for the periodic timer table: random and directed commands, predicted results.
module tb_periodic_timer_table;
    import ptt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

    class timer_scoreboard;
        logic              armed [MAX_IDS];
        logic [IVAL_W-1:0] period [MAX_IDS];
        logic [TIME_W-1:0] due_at [MAX_IDS];
        logic [COUNT_W-1:0] armed_count;
        rsp_t              pending[$];
        int                failures;

        function new();
            for (int i = 0; i < MAX_IDS; i++)
            begin
                armed[i] = 1'b0;
                period[i] = '0;
                due_at[i] = '0;
            end
            armed_count = '0;
            failures = 0;
        endfunction

        function logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
            logic [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? TIME_TOP : s[TIME_W-1:0];
        endfunction

        function rsp_t make(logic k, logic [1:0] st, logic [ID_W-1:0] id, logic l);
            rsp_t r;
            r.kind = k;
            r.status = st;
            r.fired_id = id;
            r.active_count = armed_count;
            r.last = l;
            return r;
        endfunction

        function void note_request(req_t q);
            logic [1:0] st;
            logic [TIME_W-1:0] gap;
            logic [TIME_W-1:0] iv;
            st = STAT_OK;
            case (action_t'(q.action))
                ACT_ADD:
                begin
                    if (q.interval == 0)
                        st = STAT_BAD_IVAL;
                    else if (armed[q.timer_id])
                        st = STAT_USED;
                    else
                    begin
                        armed[q.timer_id] = 1'b1;
                        period[q.timer_id] = q.interval;
                        due_at[q.timer_id] = sat_sum(q.now, TIME_W'(q.interval));
                        armed_count++;
                    end
                    pending.push_back(make(KIND_STATUS, st, q.timer_id, 1'b1));
                end
                ACT_REMOVE:
                begin
                    if (!armed[q.timer_id])
                        st = STAT_NOT_FOUND;
                    else
                    begin
                        armed[q.timer_id] = 1'b0;
                        armed_count--;
                    end
                    pending.push_back(make(KIND_STATUS, st, q.timer_id, 1'b1));
                end
                ACT_UPDATE:
                begin
                    for (int i = 0; i < MAX_IDS; i++)
                    begin
                        if (armed[i] && q.now >= due_at[i])
                        begin
                            iv = TIME_W'(period[i]);
                            gap = ((q.now - due_at[i]) / iv) * iv;
                            due_at[i] = sat_sum(due_at[i] + gap, iv);
                            pending.push_back(make(KIND_FIRE, STAT_OK, ID_W'(i), 1'b0));
                        end
                    end
                    pending.push_back(make(KIND_STATUS, STAT_OK, '0, 1'b1));
                end
                default:
                    pending.push_back(make(KIND_STATUS, STAT_OK, q.timer_id, 1'b1));
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                failures++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
            begin
                $error("kind: expected %0d actual %0d", exp.kind, got.kind);
                failures++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d actual %0d", exp.status, got.status);
                failures++;
            end
            if (got.fired_id !== exp.fired_id)
            begin
                $error("fired_id: expected %0d actual %0d", exp.fired_id, got.fired_id);
                failures++;
            end
            if (got.active_count !== exp.active_count)
            begin
                $error("active_count: expected %0d actual %0d", exp.active_count,
                       got.active_count);
                failures++;
            end
            if (got.last !== exp.last)
            begin
                $error("last: expected %0d actual %0d", exp.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    timer_scoreboard timers;
    logic [TIME_W-1:0] clock_now;
    bit idle_free;
    bit hold_off;

    periodic_timer_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [IVAL_W-1:0] rand_period();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return '0;
            2: return IVAL_W'($urandom_range(1, 3));
            default: return IVAL_W'($urandom_range(1, 400));
        endcase
    endfunction

    task automatic send(logic [1:0] act, logic [ID_W-1:0] id, logic [IVAL_W-1:0] iv,
                        logic [TIME_W-1:0] t);
        req_t q;
        q.action = act;
        q.timer_id = id;
        q.interval = iv;
        q.now = t;
        while (!idle_free && $urandom_range(0, 99) < 24)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        do
            @(posedge clk);
        while (!req_ready);
        timers.note_request(q);
    endtask

    task automatic send_random(bit well_formed);
        logic [TIME_W-1:0] t;
        int pick;
        pick = $urandom_range(0, 9);
        if (!well_formed)
        begin
            t = TIME_W'({$urandom(), $urandom()});
            send(2'($urandom_range(0, 3)), 4'($urandom()), $urandom(), t);
            return;
        end
        if (pick < 4)
        begin
            clock_now = clock_now + $urandom_range(0, 600);
            send(ACT_UPDATE, 4'($urandom()), $urandom(), clock_now);
        end
        else if (pick < 8)
            send(ACT_ADD, 4'($urandom()), rand_period(), clock_now);
        else
            send(ACT_REMOVE, 4'($urandom()), $urandom(), clock_now);
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            timers.check_result(rsp);
    end

    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                for (stall = 0; stall < 400; stall++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            rsp_ready <= idle_free || ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        int guard;
        timers = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        clock_now = '0;
        idle_free = 1'b0;
        hold_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACT_ADD, 4'd0, '0, 48'd0);
        send(ACT_ADD, 4'd0, 32'd1, 48'd0);
        send(ACT_ADD, 4'd0, 32'd5, 48'd0);
        send(ACT_REMOVE, 4'd7, '0, 48'd0);
        send(ACT_ADD, 4'd15, {IVAL_W{1'b1}}, TIME_TOP - 48'd3);
        send(ACT_ADD, 4'd7, 32'd3, 48'd0);
        send(ACT_UPDATE, 4'd0, '0, 48'd0);
        send(ACT_UPDATE, 4'd0, '0, 48'd2);
        send(ACT_UPDATE, 4'd0, '0, 48'd100);
        send(ACT_NONE, 4'd9, 32'hA5A5_5A5A, 48'h5555_AAAA_5555);
        send(ACT_NONE, 4'd6, 32'h5A5A_A5A5, 48'hAAAA_5555_AAAA);
        send(ACT_UPDATE, 4'd0, '0, TIME_TOP);
        send(ACT_UPDATE, 4'd0, '0, TIME_TOP);
        send(ACT_REMOVE, 4'd15, '0, 48'd0);
        send(ACT_REMOVE, 4'd15, '0, 48'd0);
        send(ACT_REMOVE, 4'd0, '0, 48'd0);
        send(ACT_REMOVE, 4'd7, '0, 48'd0);
        for (int i = 0; i < MAX_IDS; i++)
            send(ACT_ADD, ID_W'(i), 32'd2, 48'd10);
        send(ACT_UPDATE, 4'd0, '0, 48'd20);
        for (int i = 0; i < MAX_IDS; i++)
            send(ACT_REMOVE, ID_W'(i), '0, 48'd0);

        hold_off = 1'b1;
        for (int n = 0; n < 50; n++)
            send_random(1'b1);
        idle_free = 1'b1;
        for (int n = 0; n < 40; n++)
            send_random(1'b1);
        idle_free = 1'b0;
        for (int n = 0; n < 90; n++)
            send_random($urandom_range(0, 9) != 0);
        req_valid <= 1'b0;

        guard = 0;
        while (timers.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (1000) @(posedge clk);
        if (timers.failures == 0 && timers.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
